/* sv/pcicfg_pkg.sv */
// ----------------------------------------------------------------------------
// PCI configuration space package
// Item types, access codes and the header image used by the configuration
// space block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcicfg_pkg;

  // Access kinds. The fourth code is unused and is ignored by the block.
  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_RELOAD = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_offset;
    logic [2:0]  access_size;
    logic [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [31:0] bar0_base;
  } out_item_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_VENDOR    = 2'd0;
  localparam logic [1:0] CFG_DEVICE    = 2'd1;
  localparam logic [1:0] CFG_BAR0_LOG2 = 2'd2;
  localparam logic [1:0] CFG_MSIX_TBL  = 2'd3;

  localparam logic [15:0] VENDOR_RST    = 16'h0000;
  localparam logic [15:0] DEVICE_RST    = 16'h0000;
  localparam logic [4:0]  BAR0_LOG2_RST = 5'd12;
  localparam logic [31:0] MSIX_TBL_RST  = 32'h0000_0800;

  localparam logic [7:0]  BAR0_OFFSET   = 8'h10;
  localparam logic [6:0]  BAR0_DWORD    = 7'd4;
  localparam logic [31:0] BAR0_BASE_MSK = 32'hFFFF_F000;

  // Header image dwords, little endian.
  localparam logic [4:0]  HDR_DW_IDENT  = 5'd0;
  localparam logic [4:0]  HDR_DW_STATUS = 5'd1;
  localparam logic [4:0]  HDR_DW_CLASS  = 5'd2;
  localparam logic [4:0]  HDR_DW_CAPPTR = 5'd13;
  localparam logic [4:0]  HDR_DW_MSIX   = 5'd16;
  localparam logic [4:0]  HDR_DW_MSIXT  = 5'd17;
  localparam logic [4:0]  HDR_DW_PBA    = 5'd18;

  localparam logic [31:0] HDR_STATUS    = 32'h0010_0000;
  localparam logic [31:0] HDR_CLASS     = 32'hFF00_0001;
  localparam logic [31:0] HDR_CAPPTR    = 32'h0000_0040;
  localparam logic [31:0] HDR_MSIX_CAP  = 32'h0000_0011;
  localparam logic [31:0] HDR_PBA       = 32'h0000_0C00;

  // Number of bytes touched by an access: 4, 2, otherwise 1.
  function automatic logic [2:0] byte_count(logic [2:0] size);
    logic [2:0] n;
    n = 3'd1;
    if (size == 3'd4) begin
      n = 3'd4;
    end else if (size == 3'd2) begin
      n = 3'd2;
    end
    return n;
  endfunction

  // Header image dword at dword index dw (only the first 32 dwords carry data).
  function automatic logic [31:0] hdr_dword(logic [4:0] dw, logic [15:0] vendor,
                                            logic [15:0] device, logic [31:0] msix);
    logic [31:0] v;
    case (dw)
      HDR_DW_IDENT:  v = {device, vendor};
      HDR_DW_STATUS: v = HDR_STATUS;
      HDR_DW_CLASS:  v = HDR_CLASS;
      HDR_DW_CAPPTR: v = HDR_CAPPTR;
      HDR_DW_MSIX:   v = HDR_MSIX_CAP;
      HDR_DW_MSIXT:  v = msix;
      HDR_DW_PBA:    v = HDR_PBA;
      default:       v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* sv/pci_config_space_with_bar_sizing.sv */
// ----------------------------------------------------------------------------
// PCI type-0 configuration space with BAR0 sizing
// Byte-addressable configuration space with header reload, BAR0 size probing
// and 1, 2 or 4 byte reads and writes.
// ----------------------------------------------------------------------------
//
// Usage. Items arrive on the in channel (valid/ready) and are reads, writes or
// header reloads. Only a read produces an item on the out channel, carrying the
// little-endian bytes read and the current BAR0 base. Writes at offset 0x10
// program BAR0 through the size mask; other writes store bytes unprotected.
//
// Timing. A read's result is valid in the cycle after the read is accepted.
// Reads and writes are accepted one per cycle while no rewrite runs and the
// receiver does not stall: the space is held in two dword-wide banks (even
// and odd dwords), so any unaligned access of up to four bytes touches each
// bank once. A reload rewrites the whole space one dword pair per cycle, and
// no item is accepted then.
//
// Reset. After reset the same header rewrite runs with the reset register
// values; in_ready_o stays low during it. The configuration port is always
// open. When the receiver stalls, the pending result holds and a new item is
// taken only in the cycle it is drained.
// ----------------------------------------------------------------------------
`default_nettype none

module pci_config_space_with_bar_sizing #(
  parameter int SPACE_BYTES = 256
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  pcicfg_pkg::in_item_t     in_item_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output pcicfg_pkg::out_item_t    out_item_o,
  input  wire                      cfg_we_i,
  input  wire [1:0]                cfg_index_i,
  input  wire [31:0]               cfg_data_i
);

  // Each bank holds every other dword of the space.
  localparam int BANK_DEPTH = (SPACE_BYTES + 7) / 8;
  localparam int BAW        = $clog2(BANK_DEPTH);
  localparam logic [12:0]    SPACE_LIM = 13'(SPACE_BYTES);
  localparam logic [BAW-1:0] SWEEP_END = BAW'(BANK_DEPTH - 1);

  // Configuration registers.
  logic [15:0] vendor_q;
  logic [15:0] device_q;
  logic [4:0]  bar_log2_q;
  logic [31:0] msix_q;

  // Values latched for the header rewrite; changes to these registers apply at reload.
  logic [15:0] snap_vendor_q;
  logic [15:0] snap_device_q;
  logic [31:0] snap_msix_q;

  logic           busy_q, busy_d;
  logic [BAW-1:0] sweep_q, sweep_d;

  logic [31:0] bar_q, bar_d;

  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  s1_off_q;
  logic [2:0]  s1_size_q;
  logic [31:0] s1_bar_q;

  logic [31:0] even_mem [BANK_DEPTH];
  logic [31:0] odd_mem  [BANK_DEPTH];
  logic [31:0] ev_rdata_q;
  logic [31:0] od_rdata_q;

  logic        accept;
  logic        acc_read;
  logic        acc_write;
  logic        acc_reload;

  logic [31:0] size_mask;
  logic [31:0] wr_val;
  logic [2:0]  wr_n;
  logic [2:0]  rd_n;
  logic [8:0]  wa [4];
  logic [8:0]  ra [4];
  logic [5:0]  ev_idx;
  logic [5:0]  od_idx;

  logic [3:0]     ev_be, od_be;
  logic [31:0]    ev_wdata, od_wdata;
  logic [BAW-1:0] ev_addr, od_addr;
  logic [11:0]    pair_ext;
  logic           pair_hi;
  logic [31:0]    rd_value;

  // --------------------------------------------------------------------------
  // Handshake. A result register sits between the memories and the receiver.
  // --------------------------------------------------------------------------
  assign in_ready_o = !busy_q && (!s1_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign acc_read   = accept && (in_item_i.kind == pcicfg_pkg::KIND_READ);
  assign acc_write  = accept && (in_item_i.kind == pcicfg_pkg::KIND_WRITE);
  assign acc_reload = accept && (in_item_i.kind == pcicfg_pkg::KIND_RELOAD);

  assign size_mask = 32'hFFFF_FFFF << bar_log2_q;

  // Dword k = offset/4 and k+1 are touched; the odd one of them sits at
  // offset[7:3] in the odd bank, the even one at offset[7:3] or one above.
  assign od_idx = {1'b0, in_item_i.byte_offset[7:3]};
  assign ev_idx = {1'b0, in_item_i.byte_offset[7:3]} + {5'd0, in_item_i.byte_offset[2]};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      wa[i] = {1'b0, in_item_i.byte_offset} + 9'(i);
      ra[i] = {1'b0, s1_off_q} + 9'(i);
    end
  end

  // A BAR0 write always covers the whole dword.
  always_comb begin
    wr_n   = pcicfg_pkg::byte_count(in_item_i.access_size);
    wr_val = in_item_i.write_value;
    if (in_item_i.byte_offset == pcicfg_pkg::BAR0_OFFSET) begin
      wr_n   = 3'd4;
      wr_val = (in_item_i.write_value == 32'hFFFF_FFFF) ? size_mask
                                                       : (in_item_i.write_value & size_mask);
    end
  end

  // Header rewrite: dword pair sweep_q, only the first 32 dwords carry data.
  assign pair_ext = 12'(sweep_q);
  assign pair_hi  = (pair_ext[11:4] != 8'd0);

  // Byte lanes for both banks, and the BAR0 shadow used for bar0_base.
  always_comb begin
    ev_be    = 4'd0;
    od_be    = 4'd0;
    ev_wdata = 32'd0;
    od_wdata = 32'd0;
    ev_addr  = BAW'(ev_idx);
    od_addr  = BAW'(od_idx);
    bar_d    = bar_q;
    if (busy_q) begin
      ev_be    = 4'hF;
      od_be    = 4'hF;
      ev_addr  = sweep_q;
      od_addr  = sweep_q;
      ev_wdata = pair_hi ? 32'd0 : pcicfg_pkg::hdr_dword({pair_ext[3:0], 1'b0},
                   snap_vendor_q, snap_device_q, snap_msix_q);
      od_wdata = pair_hi ? 32'd0 : pcicfg_pkg::hdr_dword({pair_ext[3:0], 1'b1},
                   snap_vendor_q, snap_device_q, snap_msix_q);
    end else if (acc_write) begin
      for (int i = 0; i < 4; i++) begin
        if ((3'(i) < wr_n) && ({4'd0, wa[i]} < SPACE_LIM)) begin
          if (wa[i][2]) begin
            od_be[wa[i][1:0]]          = 1'b1;
            od_wdata[wa[i][1:0]*8 +: 8] = wr_val[i*8 +: 8];
          end else begin
            ev_be[wa[i][1:0]]          = 1'b1;
            ev_wdata[wa[i][1:0]*8 +: 8] = wr_val[i*8 +: 8];
          end
          if (wa[i][8:2] == pcicfg_pkg::BAR0_DWORD) begin
            bar_d[wa[i][1:0]*8 +: 8] = wr_val[i*8 +: 8];
          end
        end
      end
    end else if (acc_reload) begin
      bar_d = 32'd0;
    end
  end

  // --------------------------------------------------------------------------
  // Banks: byte-lane writes, registered reads.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 4; j++) begin
      if (ev_be[j]) begin
        even_mem[ev_addr][j*8 +: 8] <= ev_wdata[j*8 +: 8];
      end
      if (od_be[j]) begin
        odd_mem[od_addr][j*8 +: 8] <= od_wdata[j*8 +: 8];
      end
    end
    if (acc_read) begin
      ev_rdata_q <= even_mem[ev_addr];
      od_rdata_q <= odd_mem[od_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Control state and configuration registers.
  // --------------------------------------------------------------------------
  always_comb begin
    busy_d  = busy_q;
    sweep_d = sweep_q;
    if (busy_q) begin
      sweep_d = sweep_q + BAW'(1);
      if (sweep_q == SWEEP_END) begin
        busy_d = 1'b0;
      end
    end else if (acc_reload) begin
      busy_d  = 1'b1;
      sweep_d = '0;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q && !out_ready_i;
    if (acc_read) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b1;
      sweep_q       <= '0;
      s1_valid_q    <= 1'b0;
      bar_q         <= 32'd0;
      vendor_q      <= pcicfg_pkg::VENDOR_RST;
      device_q      <= pcicfg_pkg::DEVICE_RST;
      bar_log2_q    <= pcicfg_pkg::BAR0_LOG2_RST;
      msix_q        <= pcicfg_pkg::MSIX_TBL_RST;
      snap_vendor_q <= pcicfg_pkg::VENDOR_RST;
      snap_device_q <= pcicfg_pkg::DEVICE_RST;
      snap_msix_q   <= pcicfg_pkg::MSIX_TBL_RST;
    end else begin
      busy_q     <= busy_d;
      sweep_q    <= sweep_d;
      s1_valid_q <= s1_valid_d;
      bar_q      <= bar_d;
      if (acc_reload) begin
        snap_vendor_q <= vendor_q;
        snap_device_q <= device_q;
        snap_msix_q   <= msix_q;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          pcicfg_pkg::CFG_VENDOR:    vendor_q   <= cfg_data_i[15:0];
          pcicfg_pkg::CFG_DEVICE:    device_q   <= cfg_data_i[15:0];
          pcicfg_pkg::CFG_BAR0_LOG2: bar_log2_q <= cfg_data_i[4:0];
          pcicfg_pkg::CFG_MSIX_TBL:  msix_q     <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Read result payload, captured with the read.
  always_ff @(posedge clk_i) begin
    if (acc_read) begin
      s1_off_q  <= in_item_i.byte_offset;
      s1_size_q <= in_item_i.access_size;
      s1_bar_q  <= bar_q & pcicfg_pkg::BAR0_BASE_MSK;
    end
  end

  // Gather the read bytes from both banks; bytes past the space read as zero.
  assign rd_n = pcicfg_pkg::byte_count(s1_size_q);

  always_comb begin
    rd_value = 32'd0;
    for (int i = 0; i < 4; i++) begin
      if ((3'(i) < rd_n) && ({4'd0, ra[i]} < SPACE_LIM)) begin
        rd_value[i*8 +: 8] = ra[i][2] ? od_rdata_q[ra[i][1:0]*8 +: 8]
                                      : ev_rdata_q[ra[i][1:0]*8 +: 8];
      end
    end
  end

  assign out_valid_o           = s1_valid_q;
  assign out_item_o.read_value = rd_value;
  assign out_item_o.bar0_base  = s1_bar_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !in_ready_o)
    else $error("item accepted during header rewrite");

  a_sweep_from_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(in_valid_i && in_ready_o &&
                            in_item_i.kind == pcicfg_pkg::KIND_RELOAD))
    else $error("header rewrite started without a reload");

  a_read_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_item_i.kind == pcicfg_pkg::KIND_READ) |=> out_valid_o)
    else $error("read produced no result");

  a_other_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_item_i.kind != pcicfg_pkg::KIND_READ) |=> !out_valid_o)
    else $error("result produced by a non-read item");

endmodule

`default_nettype wire

/* tb/pci_config_space_with_bar_sizing_test.sv */
// ----------------------------------------------------------------------------
// PCI configuration space with BAR0 sizing: self-checking testbench
// Sends reads, writes and header reloads through the valid/ready input,
// predicts every read's result from a byte-level copy of the space, and
// compares each result field by field. Runs a directed table first, then
// random phases with different register settings and idling patterns.
// ----------------------------------------------------------------------------
module pci_config_space_with_bar_sizing_test;

  localparam int SPACE         = 256;
  // A reload rewrites the space one dword pair per cycle. The pause before a
  // register write has to outlast one, since a reload leaves no result behind.
  localparam int SETTLE_CYCLES = SPACE / 8 + 8;
  localparam int PHASES        = 8;
  localparam int PER_PHASE     = 112;
  localparam int MAX_REPORTS   = 10;
  localparam int TIMEOUT_UNITS = 3_000_000;
  localparam int N_ROWS        = 25;

  // The fourth kind code has no enum member; the block must ignore it.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Access sizes. Any size other than a word or a dword moves one byte.
  localparam logic [2:0] SZ_BYTE  = 3'd1;
  localparam logic [2:0] SZ_WORD  = 3'd2;
  localparam logic [2:0] SZ_DWORD = 3'd4;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  pcicfg_pkg::in_item_t  in_item   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  pcicfg_pkg::out_item_t out_item;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  pci_config_space_with_bar_sizing #(
    .SPACE_BYTES(SPACE)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #(TIMEOUT_UNITS);
    $display("end of test: mismatches");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor: a byte-level copy of the configuration space plus the current
  // register values. Register changes only reach the space on a reload,
  // except the BAR0 size, which every BAR0 write reads live.
  // --------------------------------------------------------------------------
  logic [7:0]  space_model [SPACE];
  logic [15:0] vendor_id;
  logic [15:0] device_id;
  logic [4:0]  bar_log2;
  logic [31:0] msix_tbl;

  // Expected results of accepted reads, oldest first.
  pcicfg_pkg::out_item_t reads_due [$];
  int                    fail_count = 0;

  // Idle percentages for the sender and the receiver in the current phase.
  int send_pct = 0;
  int recv_pct = 0;

  function automatic bit idle_now(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Bytes past the end of the space read as zero and drop writes.
  function automatic logic [31:0] space_get(int unsigned at, int unsigned n);
    logic [31:0] v;
    int unsigned i;
    v = '0;
    for (i = 0; i < n; i++) begin
      if (at + i < SPACE) begin
        v |= 32'(space_model[at + i]) << (8 * i);
      end
    end
    return v;
  endfunction

  function automatic void space_put(int unsigned at, logic [31:0] v, int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      if (at + i < SPACE) begin
        space_model[at + i] = v[8*i +: 8];
      end
    end
  endfunction

  // Header image: identity, status, revision, class, capability pointer and
  // the MSI-X capability with its table and PBA dwords. Everything else is 0.
  function automatic void load_image();
    int i;
    for (i = 0; i < SPACE; i++) begin
      space_model[i] = 8'h00;
    end
    space_put(8'h00, {16'h0000, vendor_id}, 2);
    space_put(8'h02, {16'h0000, device_id}, 2);
    space_put(8'h06, 32'h0000_0010, 2);
    space_put(8'h08, 32'h0000_0001, 1);
    space_put(8'h0B, 32'h0000_00FF, 1);
    space_put(8'h34, 32'h0000_0040, 1);
    space_put(8'h40, 32'h0000_0011, 1);
    space_put(8'h44, msix_tbl, 4);
    space_put(8'h48, 32'h0000_0C00, 4);
  endfunction

  // Applies one accepted item to the model. Returns 1 with the expected
  // result when the item is a read.
  function automatic bit cfg_access(input pcicfg_pkg::in_item_t it,
                                    output pcicfg_pkg::out_item_t res);
    int unsigned n;
    logic [31:0] mask;
    bit          has_res;
    n = (it.access_size == SZ_DWORD) ? 4 : (it.access_size == SZ_WORD) ? 2 : 1;
    res = '0;
    has_res = 1'b0;
    case (it.kind)
      pcicfg_pkg::KIND_READ: begin
        res.read_value = space_get(it.byte_offset, n);
        res.bar0_base  = space_get(pcicfg_pkg::BAR0_OFFSET, 4) & pcicfg_pkg::BAR0_BASE_MSK;
        has_res = 1'b1;
      end
      pcicfg_pkg::KIND_WRITE: begin
        // A BAR0 write always covers the whole dword. All ones is the
        // sizing probe and leaves the size mask behind.
        if (it.byte_offset == pcicfg_pkg::BAR0_OFFSET) begin
          mask = 32'hFFFF_FFFF << bar_log2;
          space_put(pcicfg_pkg::BAR0_OFFSET,
                    (it.write_value == 32'hFFFF_FFFF) ? mask : (it.write_value & mask), 4);
        end else begin
          space_put(it.byte_offset, it.write_value, n);
        end
      end
      pcicfg_pkg::KIND_RELOAD: begin
        load_image();
      end
      default: begin
      end
    endcase
    return has_res;
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Holds the item until it is accepted, with random gaps in front of
  // it. The expectation is queued in the step of acceptance, which is always
  // before the block can hand the result over. A typed value, when given,
  // stands in for the predicted read data.
  // --------------------------------------------------------------------------
  task automatic push_item(input pcicfg_pkg::in_item_t it, input bit typed,
                           input logic [31:0] typed_read);
    pcicfg_pkg::out_item_t res;
    while (idle_now(send_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    if (cfg_access(it, res)) begin
      if (typed) begin
        res.read_value = typed_read;
      end
      reads_due.push_back(res);
    end
  endtask

  // One register write per edge. The caller lowers the write enable after
  // the last one so that it is never lowered and raised in the same step.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      pcicfg_pkg::CFG_VENDOR:    vendor_id = value[15:0];
      pcicfg_pkg::CFG_DEVICE:    device_id = value[15:0];
      pcicfg_pkg::CFG_BAR0_LOG2: bar_log2  = value[4:0];
      pcicfg_pkg::CFG_MSIX_TBL:  msix_tbl  = value;
      default: begin
      end
    endcase
  endtask

  // Random access. Offsets lean toward BAR0, the header and the top of the
  // space, where the interesting boundaries are. Sizes cover all eight codes.
  function automatic pcicfg_pkg::in_item_t random_access();
    pcicfg_pkg::in_item_t it;
    int                   r;
    r = $urandom_range(99);
    if (r < 45) begin
      it.kind = pcicfg_pkg::KIND_READ;
    end else if (r < 85) begin
      it.kind = pcicfg_pkg::KIND_WRITE;
    end else if (r < 93) begin
      it.kind = pcicfg_pkg::KIND_RELOAD;
    end else begin
      it.kind = KIND_UNUSED;
    end
    r = $urandom_range(9);
    if (r < 2) begin
      it.byte_offset = pcicfg_pkg::BAR0_OFFSET;
    end else if (r == 2) begin
      it.byte_offset = 8'hFC + 8'($urandom_range(3));
    end else if (r < 6) begin
      it.byte_offset = 8'($urandom_range(8'h4F));
    end else begin
      it.byte_offset = 8'($urandom_range(255));
    end
    it.access_size = 3'($urandom_range(7));
    it.write_value = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : 32'($urandom);
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver and checker. Results are compared at the edge where they are
  // taken; ready is redrawn every cycle from the phase's stall percentage.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pcicfg_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (reads_due.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("unexpected result: read_value %h bar0_base %h",
                   out_item.read_value, out_item.bar0_base);
        end
      end else begin
        want = reads_due.pop_front();
        if (out_item.read_value !== want.read_value ||
            out_item.bar0_base !== want.bar0_base) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("read mismatch: expected read_value %h bar0_base %h, got %h %h",
                     want.read_value, want.bar0_base,
                     out_item.read_value, out_item.bar0_base);
          end
        end
      end
    end
    out_ready <= !idle_now(recv_pct);
  end

  // --------------------------------------------------------------------------
  // Directed table, run with the reset register values. Rows with a typed
  // value check the read data against it directly; the rest rely on the
  // predictor. The sequence walks the header image, an unaligned read, the
  // BAR0 sizing probe, writes that run off the end of the space, odd size
  // codes, the unused kind, writes over writable header fields, and a reload
  // that restores the image.
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  offset;
    logic [2:0]  size;
    logic [31:0] wdata;
    logic        typed;
    logic [31:0] read_exp;
  } probe_row_t;

  probe_row_t probe_rows [N_ROWS] = '{
    '{pcicfg_pkg::KIND_READ,   8'h00, SZ_DWORD, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{pcicfg_pkg::KIND_READ,   8'h04, SZ_DWORD, 32'hFFFF_FFFF, 1'b1, 32'h0010_0000},
    '{pcicfg_pkg::KIND_READ,   8'h06, SZ_DWORD, 32'h0000_0000, 1'b1, 32'h0001_0010},
    '{pcicfg_pkg::KIND_READ,   8'h08, SZ_DWORD, 32'h0000_0000, 1'b1, 32'hFF00_0001},
    '{pcicfg_pkg::KIND_READ,   8'h34, SZ_BYTE,  32'h0000_0000, 1'b1, 32'h0000_0040},
    '{pcicfg_pkg::KIND_READ,   8'h44, SZ_DWORD, 32'h0000_0000, 1'b1, 32'h0000_0800},
    '{pcicfg_pkg::KIND_READ,   8'h48, SZ_WORD,  32'h0000_0000, 1'b1, 32'h0000_0C00},
    '{pcicfg_pkg::KIND_WRITE,  8'h10, SZ_DWORD, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{pcicfg_pkg::KIND_READ,   8'h10, SZ_DWORD, 32'h0000_0000, 1'b1, 32'hFFFF_F000},
    '{pcicfg_pkg::KIND_WRITE,  8'h10, SZ_BYTE,  32'h1234_5678, 1'b0, 32'h0000_0000},
    '{pcicfg_pkg::KIND_READ,   8'h12, SZ_WORD,  32'h0000_0000, 1'b1, 32'h0000_1234},
    '{pcicfg_pkg::KIND_WRITE,  8'hFE, SZ_DWORD, 32'hAABB_CCDD, 1'b0, 32'h0000_0000},
    '{pcicfg_pkg::KIND_READ,   8'hFD, SZ_DWORD, 32'h0000_0000, 1'b1, 32'h00CC_DD00},
    '{pcicfg_pkg::KIND_WRITE,  8'h20, 3'd0,     32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{pcicfg_pkg::KIND_READ,   8'h20, 3'd7,     32'h0000_0000, 1'b1, 32'h0000_00FF},
    '{pcicfg_pkg::KIND_WRITE,  8'h21, 3'd3,     32'h0000_005A, 1'b0, 32'h0000_0000},
    '{pcicfg_pkg::KIND_WRITE,  8'h22, SZ_WORD,  32'h0000_BEEF, 1'b0, 32'h0000_0000},
    '{pcicfg_pkg::KIND_READ,   8'h20, SZ_DWORD, 32'h0000_0000, 1'b1, 32'hBEEF_5AFF},
    '{KIND_UNUSED,             8'h20, SZ_DWORD, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{pcicfg_pkg::KIND_READ,   8'h20, SZ_WORD,  32'h0000_0000, 1'b1, 32'h0000_5AFF},
    '{pcicfg_pkg::KIND_WRITE,  8'h00, SZ_DWORD, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{pcicfg_pkg::KIND_READ,   8'h00, SZ_DWORD, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
    '{pcicfg_pkg::KIND_RELOAD, 8'hFF, 3'd5,     32'h0000_0000, 1'b0, 32'h0000_0000},
    '{pcicfg_pkg::KIND_READ,   8'h10, SZ_DWORD, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{pcicfg_pkg::KIND_READ,   8'h00, SZ_DWORD, 32'h0000_0000, 1'b1, 32'h0000_0000}
  };

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    probe_row_t           row;
    pcicfg_pkg::in_item_t it;
    int                   issued;
    int                   phase;
    int                   i;

    vendor_id = pcicfg_pkg::VENDOR_RST;
    device_id = pcicfg_pkg::DEVICE_RST;
    bar_log2  = pcicfg_pkg::BAR0_LOG2_RST;
    msix_tbl  = pcicfg_pkg::MSIX_TBL_RST;
    load_image();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // The block clears itself after reset with in_ready low; the directed
    // items simply wait for it.
    for (i = 0; i < N_ROWS; i++) begin
      row = probe_rows[i];
      push_item(pcicfg_pkg::in_item_t'{row.kind, row.offset, row.size, row.wdata},
                row.typed, row.read_exp);
    end

    for (phase = 0; phase < PHASES; phase++) begin
      // Registers change only with the block idle: every read answered and
      // any reload in flight given time to finish.
      in_valid <= 1'b0;
      while (reads_due.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);

      // Phase 0 takes every register to its low extreme (BAR0 size 0 makes
      // the size mask all ones), phase 1 to its high extreme, phase 2 uses
      // the smallest real BAR0 size; the rest are random. Upper data bits
      // beyond a register's width are random too and must be dropped.
      if (phase == 0) begin
        write_reg(pcicfg_pkg::CFG_VENDOR, 32'h0000_0000);
        write_reg(pcicfg_pkg::CFG_DEVICE, 32'h0000_0000);
        write_reg(pcicfg_pkg::CFG_BAR0_LOG2, 32'h0000_0000);
        write_reg(pcicfg_pkg::CFG_MSIX_TBL, 32'h0000_0000);
      end else if (phase == 1) begin
        write_reg(pcicfg_pkg::CFG_VENDOR, 32'hFFFF_FFFF);
        write_reg(pcicfg_pkg::CFG_DEVICE, 32'hFFFF_FFFF);
        write_reg(pcicfg_pkg::CFG_BAR0_LOG2, 32'hFFFF_FFFF);
        write_reg(pcicfg_pkg::CFG_MSIX_TBL, 32'hFFFF_FFFF);
      end else begin
        write_reg(pcicfg_pkg::CFG_VENDOR, $urandom);
        write_reg(pcicfg_pkg::CFG_DEVICE, $urandom);
        write_reg(pcicfg_pkg::CFG_BAR0_LOG2, (phase == 2) ? 32'd4 : $urandom);
        write_reg(pcicfg_pkg::CFG_MSIX_TBL, $urandom);
      end
      cfg_we <= 1'b0;

      // Idling pattern: none, sender gaps, receiver stalls, then both.
      case (phase % 4)
        0:       begin send_pct = 0;  recv_pct = 0;  end
        1:       begin send_pct = 87; recv_pct = 0;  end
        2:       begin send_pct = 0;  recv_pct = 87; end
        default: begin send_pct = 30; recv_pct = 30; end
      endcase

      // Pull the new identity and MSI-X values into the space first.
      push_item(pcicfg_pkg::in_item_t'{pcicfg_pkg::KIND_RELOAD, 8'h00, SZ_DWORD,
                                       32'h0000_0000}, 1'b0, '0);
      issued = 1;

      // Mostly single random accesses, with now and then the full BAR0
      // sizing sequence a host runs: probe with all ones, read the mask
      // back, then program a base address.
      while (issued < PER_PHASE) begin
        if ($urandom_range(99) < 12) begin
          push_item(pcicfg_pkg::in_item_t'{pcicfg_pkg::KIND_WRITE, pcicfg_pkg::BAR0_OFFSET,
                                           3'($urandom_range(7)), 32'hFFFF_FFFF},
                    1'b0, '0);
          push_item(pcicfg_pkg::in_item_t'{pcicfg_pkg::KIND_READ, pcicfg_pkg::BAR0_OFFSET,
                                           SZ_DWORD, 32'($urandom)},
                    1'b0, '0);
          push_item(pcicfg_pkg::in_item_t'{pcicfg_pkg::KIND_WRITE, pcicfg_pkg::BAR0_OFFSET,
                                           3'($urandom_range(7)), 32'($urandom)},
                    1'b0, '0);
          issued += 3;
        end else begin
          it = random_access();
          push_item(it, 1'b0, '0);
          if (it.kind != KIND_UNUSED) begin
            issued++;
          end
        end
      end
    end

    // Drain the last reads, then give a late reload or a stray result time
    // to show up before the verdict.
    in_valid <= 1'b0;
    while (reads_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/pcicfg_pkg.sv
sv/pci_config_space_with_bar_sizing.sv
tb/pci_config_space_with_bar_sizing_test.sv
